// File: src/ljpf_pkg.sv
// ============================================================================
// ljpf_pkg: shared constants and types for the LJ pair force pipeline
// Widths, register indexes, reset values, stage numbering, sideband type.
// ============================================================================
`default_nettype none

package ljpf_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    // multiplier operand width and magnitude limit (values stay below 2^62)
    localparam int OP_W  = 64;
    localparam int MAG_W = 62;
    // quotient width of 2^(2F) / r2
    localparam int QW = 2 * FRAC_BITS + 1;
    // width of the raw differences c0, c0-L, c0+L
    localparam int DW = ((COORD_WIDTH > 31) ? COORD_WIDTH : 31) + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_R8     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_R14    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_CLIP  = 3'd5;

    localparam logic [30:0] RST_BOX_LENGTH  = 31'd655360;
    localparam logic [31:0] RST_FORCE_SCALE = 32'h0001_0000;
    localparam logic [31:0] RST_COEF_R8     = 32'h0006_0000;
    localparam logic [31:0] RST_COEF_R14    = 32'hFFF4_0000;
    localparam logic [30:0] RST_TIME_STEP   = 31'd328;
    localparam logic [31:0] RST_FORCE_CLIP  = 32'hFF9C_0000;

    // pipeline stage numbers (sideband register set k belongs to stage k)
    localparam int ST_MI = 3;
    localparam int ST_SQ = 5;
    localparam int ST_R2 = 6;
    localparam int ST_Q  = ST_R2 + QW;
    localparam int ST_S2 = ST_Q + 2;
    localparam int ST_S4 = ST_S2 + 2;
    localparam int ST_S7 = ST_S4 + 2;
    localparam int ST_TP = ST_S7 + 2;
    localparam int ST_T  = ST_TP + 1;
    localparam int ST_U  = ST_T + 2;
    localparam int ST_UV = ST_U + 1;
    localparam int ST_V  = ST_UV + 1;
    localparam int ST_F  = ST_V + 2;
    localparam int ST_I  = ST_F + 2;
    localparam int ST_O  = ST_I + 1;

    typedef struct packed {
        logic                              v;
        logic                              bad;
        logic                              sg;
        logic [2:0][COORD_WIDTH-1:0]       mm;
        logic [2:0]                        ms;
    } t_side;

endpackage

`default_nettype wire

// File: src/ljpf_mulq.sv
// ============================================================================
// ljpf_mulq: two-stage unsigned fixed-point multiplier
// Four half-width partial products, then sum, shift by FRAC_BITS, range flag.
// ============================================================================
`default_nettype none

module ljpf_mulq (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [ljpf_pkg::OP_W-1:0] i_a,
    input  wire logic [ljpf_pkg::OP_W-1:0] i_b,
    output logic [ljpf_pkg::MAG_W-1:0]     o_res,
    output logic                           o_ovf
);

    localparam int HW = ljpf_pkg::OP_W / 2;
    localparam int PW = 2 * ljpf_pkg::OP_W;
    localparam int LO = ljpf_pkg::FRAC_BITS;
    localparam int HI = ljpf_pkg::FRAC_BITS + ljpf_pkg::MAG_W;

    logic [ljpf_pkg::OP_W-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [PW-1:0]             sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= ljpf_pkg::OP_W'(i_a[HW-1:0]) * ljpf_pkg::OP_W'(i_b[HW-1:0]);
            r_lh <= ljpf_pkg::OP_W'(i_a[HW-1:0]) * ljpf_pkg::OP_W'(i_b[ljpf_pkg::OP_W-1:HW]);
            r_hl <= ljpf_pkg::OP_W'(i_a[ljpf_pkg::OP_W-1:HW]) * ljpf_pkg::OP_W'(i_b[HW-1:0]);
            r_hh <= ljpf_pkg::OP_W'(i_a[ljpf_pkg::OP_W-1:HW])
                  * ljpf_pkg::OP_W'(i_b[ljpf_pkg::OP_W-1:HW]);
        end
    end

    assign sum = PW'(r_ll) + (PW'(r_lh) << HW) + (PW'(r_hl) << HW)
               + (PW'(r_hh) << ljpf_pkg::OP_W);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= sum[HI-1:LO];
            o_ovf <= |sum[PW-1:HI];
        end
    end

endmodule

`default_nettype wire

// File: src/ljpf_div.sv
// ============================================================================
// ljpf_div: pipelined restoring divider, 2^(2F) / d
// One quotient bit per stage, QW stages, result registered.
// ============================================================================
`default_nettype none

module ljpf_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [ljpf_pkg::OP_W-1:0] i_d,
    output logic [ljpf_pkg::QW-1:0]        o_q
);

    localparam int QW = ljpf_pkg::QW;
    localparam int W  = ljpf_pkg::OP_W;

    logic [W-1:0]  r_rem [QW];
    logic [W-1:0]  r_d   [QW];
    logic [QW-1:0] r_q   [QW];
    logic [W-1:0]  n_rem [QW];
    logic [QW-1:0] n_q   [QW];

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            logic [W:0]    trial;
            logic [W:0]    diff;
            logic [W-1:0]  d_in;
            logic [QW-1:0] q_in;
            logic          ge;
            if (j == 0) begin : g_first
                // numerator has a single one, entering at the first step
                assign trial = (W+1)'(1);
                assign d_in  = i_d;
                assign q_in  = '0;
            end else begin : g_next
                assign trial = {r_rem[j-1], 1'b0};
                assign d_in  = r_d[j-1];
                assign q_in  = r_q[j-1];
            end
            assign diff = trial - {1'b0, d_in};
            assign ge   = !diff[W];
            always_comb begin
                n_rem[j] = ge ? diff[W-1:0] : trial[W-1:0];
                n_q[j]   = q_in;
                n_q[j][QW-1-j] = ge;
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= n_rem[j];
                    r_d[j]   <= d_in;
                    r_q[j]   <= n_q[j];
                end
            end
        end
    endgenerate

    assign o_q = r_q[QW-1];

endmodule

`default_nettype wire

// File: src/lennard_jones_pair_force_top.sv
// ============================================================================
// lennard_jones_pair_force_top: Lennard-Jones pair impulse, minimum image
// Q16.16 pipeline from a particle pair to impulse = dt*force per axis.
// ============================================================================
// The 1/r^2 divider produces QW = 2F+1 quotient bits (33 at 16 fraction bits).
// Throughput: one word per cycle; every stage advances together whenever the
//   output register is empty or being taken.
// Reset (synchronous, active low): all stage valid bits cleared, config
//   registers back to their defaults. No clearing pass.
`default_nettype none

module lennard_jones_pair_force_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [ljpf_pkg::COORD_WIDTH-1:0]      i_self_x,
    input  wire logic [ljpf_pkg::COORD_WIDTH-1:0]      i_self_y,
    input  wire logic [ljpf_pkg::COORD_WIDTH-1:0]      i_self_z,
    input  wire logic [ljpf_pkg::COORD_WIDTH-1:0]      i_other_x,
    input  wire logic [ljpf_pkg::COORD_WIDTH-1:0]      i_other_y,
    input  wire logic [ljpf_pkg::COORD_WIDTH-1:0]      i_other_z,
    input  wire logic                                  i_self_empty,
    input  wire logic                                  i_other_empty,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [ljpf_pkg::COORD_WIDTH-1:0]           o_impulse_x,
    output logic [ljpf_pkg::COORD_WIDTH-1:0]           o_impulse_y,
    output logic [ljpf_pkg::COORD_WIDTH-1:0]           o_impulse_z,
    output logic                                       o_masked,
    // config write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [ljpf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [ljpf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CW = ljpf_pkg::COORD_WIDTH;
    localparam int DW = ljpf_pkg::DW;
    localparam int OW = ljpf_pkg::OP_W;
    localparam int MW = ljpf_pkg::MAG_W;
    localparam int QW = ljpf_pkg::QW;
    localparam int NS = ljpf_pkg::ST_O;
    localparam logic [MW-1:0] HI_LIM = MW'(1) << (CW - 1);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [30:0] r_box_length;
    logic [31:0] r_force_scale;
    logic [31:0] r_coef_r8;
    logic [31:0] r_coef_r14;
    logic [30:0] r_time_step;
    logic [31:0] r_force_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_length  <= ljpf_pkg::RST_BOX_LENGTH;
            r_force_scale <= ljpf_pkg::RST_FORCE_SCALE;
            r_coef_r8     <= ljpf_pkg::RST_COEF_R8;
            r_coef_r14    <= ljpf_pkg::RST_COEF_R14;
            r_time_step   <= ljpf_pkg::RST_TIME_STEP;
            r_force_clip  <= ljpf_pkg::RST_FORCE_CLIP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ljpf_pkg::REG_BOX_LENGTH:  r_box_length  <= i_cfg_data[30:0];
                ljpf_pkg::REG_FORCE_SCALE: r_force_scale <= i_cfg_data;
                ljpf_pkg::REG_COEF_R8:     r_coef_r8     <= i_cfg_data;
                ljpf_pkg::REG_COEF_R14:    r_coef_r14    <= i_cfg_data;
                ljpf_pkg::REG_TIME_STEP:   r_time_step   <= i_cfg_data[30:0];
                ljpf_pkg::REG_FORCE_CLIP:  r_force_clip  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sign/magnitude forms of the signed registers; static between items.
    logic        scale_neg, c8_neg, c14_neg;
    logic [32:0] scale_mag, c8_mag, c14_mag;
    logic [63:0] clip64;

    assign scale_neg = r_force_scale[31];
    assign c8_neg    = r_coef_r8[31];
    assign c14_neg   = r_coef_r14[31];
    assign scale_mag = scale_neg ? (~{1'b1, r_force_scale} + 33'd1) : {1'b0, r_force_scale};
    assign c8_mag    = c8_neg    ? (~{1'b1, r_coef_r8} + 33'd1)     : {1'b0, r_coef_r8};
    assign c14_mag   = c14_neg   ? (~{1'b1, r_coef_r14} + 33'd1)    : {1'b0, r_coef_r14};
    assign clip64    = {{32{r_force_clip[31]}}, r_force_clip};

    // ------------------------------------------------------------------
    // Global advance: the whole pipe moves when the output slot frees up.
    // Valid bits ride along in the sideband, so bubbles cost nothing.
    // ------------------------------------------------------------------
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    ljpf_pkg::t_side r_sd [1:NS];
    ljpf_pkg::t_side n_sd [1:NS];

    // ------------------------------------------------------------------
    // Stages 1-3: minimum image per axis
    // ------------------------------------------------------------------
    logic [CW-1:0] self_c  [3];
    logic [CW-1:0] other_c [3];
    assign self_c[0]  = i_self_x;
    assign self_c[1]  = i_self_y;
    assign self_c[2]  = i_self_z;
    assign other_c[0] = i_other_x;
    assign other_c[1] = i_other_y;
    assign other_c[2] = i_other_z;

    logic [DW-1:0] len_e;
    logic [DW-1:0] n_c [3][3];
    logic [DW-1:0] r_c [3][3];
    logic [DW-1:0] n_a [3][3];
    logic [DW-1:0] r_a [3][3];
    logic          r_cs [3][3];

    assign len_e = DW'(r_box_length);

    // candidates: d, d - L, d + L (two's complement in DW bits)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [DW-1:0] se, oe, d;
            se = {{(DW-CW){self_c[k][CW-1]}}, self_c[k]};
            oe = {{(DW-CW){other_c[k][CW-1]}}, other_c[k]};
            d  = oe - se;
            n_c[k][0] = d;
            n_c[k][1] = d - len_e;
            n_c[k][2] = d + len_e;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_a[k][j] = r_c[k][j][DW-1] ? (~r_c[k][j] + DW'(1)) : r_c[k][j];
            end
        end
    end

    // strict minimum of the three magnitudes, else a tie
    logic [2:0][CW-1:0] sel_mag;
    logic [2:0]         sel_sgn;
    logic               any_tie;

    always_comb begin
        any_tie = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_a[k][0] < r_a[k][1] && r_a[k][0] < r_a[k][2]) begin
                sel_mag[k] = r_a[k][0][CW-1:0];
                sel_sgn[k] = r_cs[k][0];
            end else if (r_a[k][1] < r_a[k][0] && r_a[k][1] < r_a[k][2]) begin
                sel_mag[k] = r_a[k][1][CW-1:0];
                sel_sgn[k] = r_cs[k][1];
            end else if (r_a[k][2] < r_a[k][0] && r_a[k][2] < r_a[k][1]) begin
                sel_mag[k] = r_a[k][2][CW-1:0];
                sel_sgn[k] = r_cs[k][2];
            end else begin
                sel_mag[k] = r_a[k][0][CW-1:0];
                sel_sgn[k] = 1'b0;
                any_tie    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_c[k][j]  <= n_c[k][j];
                    r_a[k][j]  <= n_a[k][j];
                    r_cs[k][j] <= r_c[k][j][DW-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 4-6: squares and r^2
    // ------------------------------------------------------------------
    logic [MW-1:0] sq [3];
    logic          sq_ovf [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_sq
            ljpf_mulq u_sq (
                .i_clk (i_clk),
                .i_en  (en),
                .i_a   (OW'(r_sd[ljpf_pkg::ST_MI].mm[g])),
                .i_b   (OW'(r_sd[ljpf_pkg::ST_MI].mm[g])),
                .o_res (sq[g]),
                .o_ovf (sq_ovf[g])
            );
        end
    endgenerate

    logic [OW-1:0] r2_sum;
    logic [OW-1:0] r_r2;
    assign r2_sum = OW'(sq[0]) + OW'(sq[1]) + OW'(sq[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r2 <= r2_sum;
        end
    end

    // ------------------------------------------------------------------
    // s = 2^(2F) / r2, then the power chain s^2, s^3, s^4, s^7
    // ------------------------------------------------------------------
    logic [QW-1:0] q;

    ljpf_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_r2),
        .o_q   (q)
    );

    logic [MW-1:0] s2, s3, s4, s7;
    logic          s2_ovf, s3_ovf, s4_ovf, s7_ovf;
    logic [QW-1:0] r_s_d1, r_s_d2;
    logic [MW-1:0] r_s4_d1, r_s4_d2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_d1  <= q;
            r_s_d2  <= r_s_d1;
            r_s4_d1 <= s4;
            r_s4_d2 <= r_s4_d1;
        end
    end

    ljpf_mulq u_s2 (
        .i_clk (i_clk), .i_en (en),
        .i_a (OW'(q)), .i_b (OW'(q)),
        .o_res (s2), .o_ovf (s2_ovf)
    );

    ljpf_mulq u_s4 (
        .i_clk (i_clk), .i_en (en),
        .i_a (OW'(s2)), .i_b (OW'(s2)),
        .o_res (s4), .o_ovf (s4_ovf)
    );

    ljpf_mulq u_s3 (
        .i_clk (i_clk), .i_en (en),
        .i_a (OW'(s2)), .i_b (OW'(r_s_d2)),
        .o_res (s3), .o_ovf (s3_ovf)
    );

    ljpf_mulq u_s7 (
        .i_clk (i_clk), .i_en (en),
        .i_a (OW'(s4)), .i_b (OW'(s3)),
        .o_res (s7), .o_ovf (s7_ovf)
    );

    // ------------------------------------------------------------------
    // t = c8/r^8 + c14/r^14
    // ------------------------------------------------------------------
    logic [MW-1:0] p8, p14;
    logic          p8_ovf, p14_ovf;

    ljpf_mulq u_p8 (
        .i_clk (i_clk), .i_en (en),
        .i_a (OW'(c8_mag)), .i_b (OW'(r_s4_d2)),
        .o_res (p8), .o_ovf (p8_ovf)
    );

    ljpf_mulq u_p14 (
        .i_clk (i_clk), .i_en (en),
        .i_a (OW'(c14_mag)), .i_b (OW'(s7)),
        .o_res (p14), .o_ovf (p14_ovf)
    );

    logic [OW-1:0] t8, t14, t_sum, t_mag;
    logic [MW-1:0] r_tmag;

    assign t8    = c8_neg  ? (~OW'(p8) + OW'(1))  : OW'(p8);
    assign t14   = c14_neg ? (~OW'(p14) + OW'(1)) : OW'(p14);
    assign t_sum = t8 + t14;
    assign t_mag = t_sum[OW-1] ? (~t_sum + OW'(1)) : t_sum;

    // ------------------------------------------------------------------
    // u = scale*t, v = max(u, clip), f = dt*v
    // ------------------------------------------------------------------
    logic [MW-1:0] pu;
    logic          pu_ovf;
    logic [OW-1:0] r_u;
    logic [OW-1:0] v_val;
    logic [MW-1:0] r_vmag;

    ljpf_mulq u_pu (
        .i_clk (i_clk), .i_en (en),
        .i_a (OW'(scale_mag)), .i_b (OW'(r_tmag)),
        .o_res (pu), .o_ovf (pu_ovf)
    );

    assign v_val = ($signed(r_u) > $signed(clip64)) ? r_u : clip64;

    logic [MW-1:0] fmag;
    logic          f_ovf;

    ljpf_mulq u_pf (
        .i_clk (i_clk), .i_en (en),
        .i_a (OW'(r_time_step)), .i_b (OW'(r_vmag)),
        .o_res (fmag), .o_ovf (f_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tmag <= t_mag[MW-1:0];
            r_u    <= (r_sd[ljpf_pkg::ST_U].sg ^ scale_neg) ? (~OW'(pu) + OW'(1)) : OW'(pu);
            r_vmag <= v_val[OW-1] ? MW'(~v_val + OW'(1)) : v_val[MW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // impulse = f * difference, range check, output register
    // ------------------------------------------------------------------
    logic [MW-1:0] pimp [3];
    logic          pimp_ovf [3];

    generate
        for (g = 0; g < 3; g++) begin : g_imp
            ljpf_mulq u_imp (
                .i_clk (i_clk),
                .i_en  (en),
                .i_a   (OW'(r_sd[ljpf_pkg::ST_F].mm[g])),
                .i_b   (OW'(fmag)),
                .o_res (pimp[g]),
                .o_ovf (pimp_ovf[g])
            );
        end
    endgenerate

    logic [CW-1:0] imp_val [3];
    logic          out_bad;

    always_comb begin
        out_bad = r_sd[ljpf_pkg::ST_I].bad;
        for (int k = 0; k < 3; k++) begin
            logic sgn;
            sgn = r_sd[ljpf_pkg::ST_I].ms[k] ^ r_sd[ljpf_pkg::ST_I].sg;
            // negative side may reach -2^(CW-1), positive side stops short
            if (pimp_ovf[k] || (sgn ? (pimp[k] > HI_LIM) : (pimp[k] >= HI_LIM))) begin
                out_bad = 1'b1;
            end
            imp_val[k] = sgn ? (~pimp[k][CW-1:0] + CW'(1)) : pimp[k][CW-1:0];
        end
    end

    logic [CW-1:0] r_imp [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_imp[k] <= out_bad ? '0 : imp_val[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sideband: valid, mask flag, chosen differences, running sign.
    // Each fault folds into the mask one stage after it is known.
    // ------------------------------------------------------------------
    always_comb begin
        n_sd[1]     = '0;
        n_sd[1].v   = i_in_valid;
        n_sd[1].bad = i_self_empty || i_other_empty;
        for (int i = 2; i <= NS; i++) begin
            n_sd[i] = r_sd[i-1];
        end

        n_sd[ljpf_pkg::ST_MI].mm  = sel_mag;
        n_sd[ljpf_pkg::ST_MI].ms  = sel_sgn;
        n_sd[ljpf_pkg::ST_MI].bad = r_sd[ljpf_pkg::ST_MI-1].bad || any_tie;

        // coincident pair or r^2 out of range
        n_sd[ljpf_pkg::ST_R2].bad = r_sd[ljpf_pkg::ST_R2-1].bad
                                 || sq_ovf[0] || sq_ovf[1] || sq_ovf[2]
                                 || (r2_sum[OW-1:MW] != '0) || (r2_sum == '0);

        n_sd[ljpf_pkg::ST_S2+1].bad = r_sd[ljpf_pkg::ST_S2].bad || s2_ovf;
        n_sd[ljpf_pkg::ST_S4+1].bad = r_sd[ljpf_pkg::ST_S4].bad || s4_ovf || s3_ovf;
        n_sd[ljpf_pkg::ST_S7+1].bad = r_sd[ljpf_pkg::ST_S7].bad || s7_ovf;

        n_sd[ljpf_pkg::ST_T].bad = r_sd[ljpf_pkg::ST_TP].bad || p8_ovf || p14_ovf
                                || (t_mag[OW-1:MW] != '0);
        n_sd[ljpf_pkg::ST_T].sg  = t_sum[OW-1];

        n_sd[ljpf_pkg::ST_UV].bad = r_sd[ljpf_pkg::ST_U].bad || pu_ovf;

        n_sd[ljpf_pkg::ST_V].sg = v_val[OW-1];

        n_sd[ljpf_pkg::ST_F+1].bad = r_sd[ljpf_pkg::ST_F].bad || f_ovf;

        n_sd[ljpf_pkg::ST_O].bad = out_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= NS; i++) begin
                r_sd[i].v <= 1'b0;
            end
        end else if (en) begin
            for (int i = 1; i <= NS; i++) begin
                r_sd[i] <= n_sd[i];
            end
        end
    end

    assign o_out_valid = r_sd[NS].v;
    assign o_masked    = r_sd[NS].bad;
    assign o_impulse_x = r_imp[0];
    assign o_impulse_y = r_imp[1];
    assign o_impulse_z = r_imp[2];

`ifndef SYNTHESIS
    // a masked word never carries a nonzero impulse
    a_masked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_masked |->
            (o_impulse_x == '0) && (o_impulse_y == '0) && (o_impulse_z == '0))
        else $error("masked word with nonzero impulse");

    // a held output word stops the input side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // while stalled, mid-pipe data does not move
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_r2) && $stable(r_tmag))
        else $error("pipeline advanced during stall");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Lennard-Jones pair force pipeline
// Streams particle pairs through valid/ready with random idling, predicts the
// impulse word of every accepted pair in a scoreboard and checks it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ljpf_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 64;   // settle time after the last expected word
    localparam int STALL_CYCLES    = 400;  // long receiver hold-off
    localparam int PHASE_ITEMS     = 280;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] sx, sy, sz, ox, oy, oz;
        logic                          se, oe;
    } pair_t;

    typedef struct {
        logic [COORD_WIDTH-1:0] ix, iy, iz;
        logic                   m;
    } impulse_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers and a fixed-point force predictor
    // ------------------------------------------------------------------------
    class force_board;
        impulse_t exp_q[$];
        int       errors;
        longint   box, scale, c8, c14, dt, clip;

        function new();
            errors = 0;
            box   = 655360;
            scale = 65536;
            c8    = 393216;
            c14   = -786432;
            dt    = 328;
            clip  = -6553600;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_BOX_LENGTH:  box   = longint'({1'b0, d[30:0]});
                REG_FORCE_SCALE: scale = longint'($signed(d));
                REG_COEF_R8:     c8    = longint'($signed(d));
                REG_COEF_R14:    c14   = longint'($signed(d));
                REG_TIME_STEP:   dt    = longint'({1'b0, d[30:0]});
                REG_FORCE_CLIP:  clip  = longint'($signed(d));
                default: ;
            endcase
        endfunction

        function logic [63:0] mag(longint v);
            return (v < 0) ? 64'(-v) : 64'(v);
        endfunction

        // truncated Q16.16 product of magnitudes, flags 2^62 and above
        function logic [63:0] umul(logic [63:0] a, logic [63:0] b, inout bit ovf);
            logic [127:0] pr;
            pr = {64'd0, a} * {64'd0, b};
            pr = pr >> FRAC_BITS;
            if (pr >= (128'd1 << 62))
                ovf = 1'b1;
            return pr[63:0];
        endfunction

        function longint smul(longint a, longint b, inout bit ovf);
            logic [63:0] p;
            p = umul(mag(a), mag(b), ovf);
            if (ovf)
                return 0;
            return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
        endfunction

        // nearest periodic image, no strict minimum means a tie
        function longint min_img(longint s, longint o, inout bit tie);
            longint      d0, d1, d2;
            logic [63:0] a0, a1, a2;
            d0 = o - s;
            d1 = d0 - box;
            d2 = d0 + box;
            a0 = mag(d0);
            a1 = mag(d1);
            a2 = mag(d2);
            if (a0 < a1 && a0 < a2) return d0;
            if (a1 < a0 && a1 < a2) return d1;
            if (a2 < a0 && a2 < a1) return d2;
            tie = 1'b1;
            return 0;
        endfunction

        function impulse_t predict(pair_t p);
            bit          bad, tie;
            longint      m[3], imp[3];
            logic [63:0] r2, s, s2, s3, s4, s7;
            longint      t, u, v, f;
            impulse_t    r;
            bad = 0;
            tie = 0;
            r2  = 0;
            f   = 0;
            imp = '{0, 0, 0};
            m[0] = min_img(longint'(p.sx), longint'(p.ox), tie);
            m[1] = min_img(longint'(p.sy), longint'(p.oy), tie);
            m[2] = min_img(longint'(p.sz), longint'(p.oz), tie);
            if (p.se || p.oe || tie)
                bad = 1;
            for (int k = 0; k < 3 && !bad; k++) begin
                r2 += umul(mag(m[k]), mag(m[k]), bad);
                if (r2 >= (64'd1 << 62))
                    bad = 1;
            end
            if (!bad && r2 == 0)
                bad = 1;
            if (!bad) begin
                s  = (64'd1 << (2 * FRAC_BITS)) / r2;
                s2 = umul(s, s, bad);
                s4 = umul(s2, s2, bad);
                s3 = umul(s2, s, bad);
                s7 = umul(s4, s3, bad);
                if (!bad) begin
                    t = smul(c8, longint'(s4), bad);
                    if (!bad)
                        t += smul(c14, longint'(s7), bad);
                    if (!bad && mag(t) >= (64'd1 << 62))
                        bad = 1;
                    if (!bad) begin
                        u = smul(scale, t, bad);
                        v = (u > clip) ? u : clip;
                        if (!bad)
                            f = smul(dt, v, bad);
                        for (int k = 0; k < 3 && !bad; k++) begin
                            imp[k] = smul(m[k], f, bad);
                            if (!bad && (imp[k] >= 64'sd2147483648 ||
                                         imp[k] < -64'sd2147483648))
                                bad = 1;
                        end
                    end
                end
            end
            r.ix = bad ? '0 : imp[0][COORD_WIDTH-1:0];
            r.iy = bad ? '0 : imp[1][COORD_WIDTH-1:0];
            r.iz = bad ? '0 : imp[2][COORD_WIDTH-1:0];
            r.m  = bad;
            return r;
        endfunction

        function void note_pair(pair_t p);
            exp_q.push_back(predict(p));
        endfunction

        function void check_word(impulse_t a);
            impulse_t e;
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected word x=%h y=%h z=%h m=%b",
                         $time, a.ix, a.iy, a.iz, a.m);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (a.ix !== e.ix) begin
                $display("%0t: impulse_x exp %h got %h", $time, e.ix, a.ix);
                errors++;
            end
            if (a.iy !== e.iy) begin
                $display("%0t: impulse_y exp %h got %h", $time, e.iy, a.iy);
                errors++;
            end
            if (a.iz !== e.iz) begin
                $display("%0t: impulse_z exp %h got %h", $time, e.iz, a.iz);
                errors++;
            end
            if (a.m !== e.m) begin
                $display("%0t: masked exp %b got %b", $time, e.m, a.m);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                   i_clk, i_rst_n;
    logic                   i_in_valid, o_in_ready;
    logic [COORD_WIDTH-1:0] i_self_x, i_self_y, i_self_z;
    logic [COORD_WIDTH-1:0] i_other_x, i_other_y, i_other_z;
    logic                   i_self_empty, i_other_empty;
    logic                   o_out_valid, i_out_ready;
    logic [COORD_WIDTH-1:0] o_impulse_x, o_impulse_y, o_impulse_z;
    logic                   o_masked;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    lennard_jones_pair_force_top u_top (.*);

    force_board board;
    bit         quiet;      // no idling on either side
    bit         stall_req;  // asks the receiver for one long hold-off
    int         idle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // every output word goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_word('{o_impulse_x, o_impulse_y, o_impulse_z, o_masked});
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= WATCHDOG_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random ready bursts, one long stall on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                i_out_ready = 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
                stall_req = 0;
            end else if (quiet) begin
                i_out_ready = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = d;
        board.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic write_all(logic [31:0] box, logic [31:0] sc, logic [31:0] k8,
                             logic [31:0] k14, logic [31:0] ts, logic [31:0] cl);
        write_reg(REG_BOX_LENGTH, box);
        write_reg(REG_FORCE_SCALE, sc);
        write_reg(REG_COEF_R8, k8);
        write_reg(REG_COEF_R14, k14);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_FORCE_CLIP, cl);
    endtask

    // hold the word until accepted, then maybe idle a burst
    task automatic send_pair(pair_t p);
        i_self_x      = p.sx;
        i_self_y      = p.sy;
        i_self_z      = p.sz;
        i_other_x     = p.ox;
        i_other_y     = p.oy;
        i_other_z     = p.oz;
        i_self_empty  = p.se;
        i_other_empty = p.oe;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pair(p);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    // wait until every expected word is out, then let the pipe settle
    task automatic drain();
        i_in_valid = 1'b0;
        while (board.exp_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic pair_t mk(int sx, int sy, int sz, int ox, int oy, int oz,
                                 bit se, bit oe);
        pair_t p;
        p = '{sx, sy, sz, ox, oy, oz, se, oe};
        return p;
    endfunction

    function automatic int near_off();
        return $urandom_range(0, 393216) - 196608;   // within +/-3.0
    endfunction

    // mostly close pairs with random content, plus wide, tie, tiny and empty
    function automatic pair_t rand_pair();
        pair_t p;
        int    sel;
        sel  = $urandom_range(0, 99);
        p.sx = $urandom;
        p.sy = $urandom;
        p.sz = $urandom;
        p.ox = p.sx + near_off();
        p.oy = p.sy + near_off();
        p.oz = p.sz + near_off();
        p.se = ($urandom_range(0, 15) == 0);
        p.oe = ($urandom_range(0, 15) == 0);
        if (sel < 8) begin
            p.ox = $urandom;
            p.oy = $urandom;
            p.oz = $urandom;
        end else if (sel < 13) begin
            p.ox = p.sx + int'(board.box / 2);        // half box: a tie when L even
        end else if (sel < 17) begin
            p.ox = p.sx + $urandom_range(0, 2) - 1;   // squares truncate away
            p.oy = p.sy;
            p.oz = p.sz;
        end else if (sel < 20) begin
            p.ox = p.sx;
            p.oy = p.sy;
            p.oz = p.sz;
        end
        return p;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_pair(rand_pair());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        board         = new();
        idle_cnt      = 0;
        quiet         = 0;
        stall_req     = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_self_x      = '0;
        i_self_y      = '0;
        i_self_z      = '0;
        i_other_x     = '0;
        i_other_y     = '0;
        i_other_z     = '0;
        i_self_empty  = 1'b0;
        i_other_empty = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed pairs at reset settings
        send_pair(mk(0, 0, 0, 65536, 0, 0, 0, 0));                 // r = 1.0
        send_pair(mk(0, 0, 0, 72000, 0, 0, 0, 0));                 // near minimum
        send_pair(mk(0, 0, 0, 0, 98304, 0, 0, 0));                 // r = 1.5
        send_pair(mk(0, 0, 0, 0, 0, 32768, 0, 0));                 // close, big force
        send_pair(mk(0, 0, 0, 6553, 0, 0, 0, 0));                  // very close
        send_pair(mk(5, 5, 5, 5, 5, 5, 0, 0));                     // coincident
        send_pair(mk(0, 0, 0, 1, 1, 1, 0, 0));                     // squares vanish
        send_pair(mk(0, 0, 0, 65536, 0, 0, 1, 0));                 // self empty
        send_pair(mk(0, 0, 0, 65536, 0, 0, 0, 1));                 // other empty
        send_pair(mk(0, 0, 0, 65536, 0, 0, 1, 1));
        send_pair(mk(0, 0, 0, 327680, 65536, 0, 0, 0));            // tie at half box
        send_pair(mk(0, 0, 0, 589824, 0, 0, 0, 0));                // wraps to -1.0
        send_pair(mk(0, 0, 0, -589824, 0, 0, 0, 0));               // wraps to +1.0
        send_pair(mk(-2147483648, -2147483648, -2147483648,
                     2147483647, 2147483647, 2147483647, 0, 0));   // coordinate extremes
        send_pair(mk(2147483647, 2147483647, 2147483647,
                     -2147483648, -2147483648, -2147483648, 0, 0));
        send_pair(mk(-1, -1, -1, 0, 0, 0, 0, 0));
        send_pair(mk(100000, -200000, 300000, 140000, -150000, 260000, 0, 0));
        run_random(PHASE_ITEMS / 2);

        // receiver holds off long while pairs keep coming: pipe fills
        stall_req = 1;
        run_random(PHASE_ITEMS / 2);
        drain();

        // huge box: far pairs where 1/r^2 truncates to zero
        write_all(32'h7FFF_FFFF, 32'd65536, 32'd393216, -32'sd786432, 32'd65536,
                  32'd6553600);
        send_pair(mk(0, 0, 0, 0, 0, 20000000, 0, 0));
        run_random(PHASE_ITEMS);
        drain();

        // extremes
        write_all(32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
        run_random(PHASE_ITEMS);
        drain();

        // random moderate settings
        write_all($urandom_range(65536, 1 << 21), $urandom_range(0, 1 << 18) - (1 << 17),
                  $urandom_range(0, 1 << 22) - (1 << 21),
                  $urandom_range(0, 1 << 22) - (1 << 21),
                  $urandom_range(0, 1 << 16), $urandom);
        run_random(PHASE_ITEMS);
        drain();

        // zero box (every axis ties), other extremes
        write_all(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
                  32'h8000_0000);
        run_random(PHASE_ITEMS / 4);
        drain();

        // back to the defaults, last stretch without idling
        write_all(32'd655360, 32'h0001_0000, 32'h0006_0000, 32'hFFF4_0000, 32'd328,
                  32'hFF9C_0000);
        run_random(PHASE_ITEMS / 2);
        quiet = 1;
        run_random(PHASE_ITEMS);
        drain();

        if (board.errors == 0 && board.exp_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
